FILE: rtl/core/button_debounce_sequence_detect_core_defines.svh
// Assertion macros shared by the debounce and sequence detect core.
// Included by the top level only; expects clk_i and rst_ni in the including scope.
`ifndef BUTTON_DEBOUNCE_SEQUENCE_DETECT_CORE_DEFINES_SVH
`define BUTTON_DEBOUNCE_SEQUENCE_DETECT_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BDSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Implication into the next cycle, checked outside reset.
`define BDSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/bdsd_pkg.sv
// Shared types and constants of the debounce and sequence detect core.
// Used by the top level, the lane and the merge stage in rtl/core.
package bdsd_pkg;

  typedef enum logic [1:0] {
    MODE_POLL = 2'd0,
    MODE_INIT = 2'd1,
    MODE_TAKE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_TIMEOUT  = 2'd1,
    REG_TABLE    = 2'd2
  } reg_idx_e;

  localparam logic [15:0] DEBOUNCE_RESET = 16'd30;
  localparam logic [15:0] TIMEOUT_RESET  = 16'd5000;
  localparam logic [31:0] TABLE_RESET    = 32'd825;

  typedef struct packed {
    logic press;   // armed button reached a debounced press
    logic stable;  // debounced pressed level after the request
  } lane_stat_t;

endpackage

FILE: rtl/core/button_debounce_sequence_detect_core.sv
// Button debouncer with press-order sequence detector.
// Each result enters a two-entry result buffer when its request is accepted;
// the buffer absorbs output stalls. Throughput: one request per cycle while
// the buffer has room; lane timers and the merge stage are combinational.
// Reset: configuration returns to defaults, all lanes released and disarmed,
// detector idle and no calibration pending; no clearing pass is needed.
`include "button_debounce_sequence_detect_core_defines.svh"

module button_debounce_sequence_detect_core #(
  parameter int NUM_BUTTONS     = 5,
  parameter int SEQUENCE_LENGTH = 4,
  parameter int TIME_WIDTH      = 32,
  localparam int CfgW = (2 * NUM_BUTTONS > 16) ? 2 * NUM_BUTTONS : 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [CfgW-1:0]        cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             mode_i,
  input  logic [TIME_WIDTH-1:0]  now_ms_i,
  input  logic [NUM_BUTTONS-1:0] pin_levels_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [1:0]             event_code_o,
  output logic                   calibration_taken_o,
  output logic [NUM_BUTTONS-1:0] btn_stable_o
);
  import bdsd_pkg::*;

  localparam int TableW = 2 * NUM_BUTTONS;
  localparam int ResW   = 3 + NUM_BUTTONS;

  logic [15:0]            debounce_q;
  logic [15:0]            timeout_q;
  logic [TableW-1:0]      table_q;
  logic                   accept;
  mode_e                  mode;
  logic [NUM_BUTTONS-1:0] pressed;
  lane_stat_t             lane_stat [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] press_vec;
  logic [NUM_BUTTONS-1:0] stable_vec;
  logic [1:0]             res_event;
  logic                   res_taken;
  logic [ResW-1:0]        res_data;
  logic [ResW-1:0]        out_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RESET;
      timeout_q  <= TIMEOUT_RESET;
      table_q    <= TableW'(TABLE_RESET);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DEBOUNCE: debounce_q <= cfg_wdata_i[15:0];
        REG_TIMEOUT:  timeout_q  <= cfg_wdata_i[15:0];
        REG_TABLE:    table_q    <= cfg_wdata_i[TableW-1:0];
        default: ;
      endcase
    end
  end

  assign accept  = in_valid_i && in_ready_o;
  assign mode    = mode_e'(mode_i);
  assign pressed = ~pin_levels_i;

  for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
    bdsd_lane #(
      .TIME_WIDTH(TIME_WIDTH)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .step_i    (accept),
      .mode_i    (mode),
      .now_i     (now_ms_i),
      .pressed_i (pressed[g]),
      .debounce_i(debounce_q),
      .stat_o    (lane_stat[g])
    );
    assign press_vec[g]  = lane_stat[g].press;
    assign stable_vec[g] = lane_stat[g].stable;
  end

  bdsd_merge #(
    .NUM_BUTTONS    (NUM_BUTTONS),
    .SEQUENCE_LENGTH(SEQUENCE_LENGTH),
    .TIME_WIDTH     (TIME_WIDTH)
  ) u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (accept),
    .mode_i   (mode),
    .now_i    (now_ms_i),
    .press_i  (press_vec),
    .table_i  (table_q),
    .timeout_i(timeout_q),
    .event_o  (res_event),
    .taken_o  (res_taken)
  );

  assign res_data = {res_event, res_taken, stable_vec};

  bdsd_outbuf #(
    .W(ResW)
  ) u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .data_i     (res_data),
    .ready_o    (in_ready_o),
    .valid_o    (out_valid_o),
    .pop_ready_i(out_ready_i),
    .data_o     (out_data)
  );

  assign event_code_o        = out_data[ResW-1 -: 2];
  assign calibration_taken_o = out_data[NUM_BUTTONS];
  assign btn_stable_o        = out_data[NUM_BUTTONS-1:0];

  `BDSD_ASSERT_NEXT(a_result_follows, accept, out_valid_o, "result missing after request")
  `BDSD_ASSERT(a_event_poll_only, accept && res_event != 2'd0 |-> mode == MODE_POLL, "stray event")
  `BDSD_ASSERT(a_taken_take_only, accept && res_taken |-> mode == MODE_TAKE, "stray calibration")
  `BDSD_ASSERT(a_full_has_output, !in_ready_o |-> out_valid_o, "buffer full without output")

endmodule

FILE: rtl/core/bdsd_lane.sv
// One button lane: raw level tracking, debounce timer and arming.
// Depends on bdsd_pkg.
module bdsd_lane #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  bdsd_pkg::mode_e       mode_i,
  input  logic [TIME_WIDTH-1:0] now_i,
  input  logic                  pressed_i,
  input  logic [15:0]           debounce_i,
  output bdsd_pkg::lane_stat_t  stat_o
);
  import bdsd_pkg::*;

  logic                  last_q, last_d;
  logic                  stable_q, stable_d;
  logic                  armed_q, armed_d;
  logic [TIME_WIDTH-1:0] ct_q, ct_d;
  logic                  changed;
  logic [TIME_WIDTH-1:0] ct_eff;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  settled;
  logic                  press;

  assign changed = pressed_i != last_q;
  assign ct_eff  = changed ? now_i : ct_q;
  assign elapsed = now_i - ct_eff;
  assign settled = (pressed_i != stable_q) && (elapsed >= TIME_WIDTH'(debounce_i));

  always_comb begin
    last_d   = last_q;
    stable_d = stable_q;
    armed_d  = armed_q;
    ct_d     = ct_q;
    press    = 1'b0;
    unique case (mode_i)
      MODE_POLL: begin
        last_d = pressed_i;
        ct_d   = ct_eff;
        if (settled) begin
          stable_d = pressed_i;
          if (pressed_i) begin
            press = armed_q;
          end else begin
            armed_d = 1'b1;
          end
        end
      end
      MODE_INIT: begin
        last_d   = pressed_i;
        stable_d = pressed_i;
        armed_d  = ~pressed_i;
        ct_d     = now_i;
      end
      default: ;
    endcase
  end

  assign stat_o.press  = press;
  assign stat_o.stable = stable_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= 1'b0;
      stable_q <= 1'b0;
      armed_q  <= 1'b0;
      ct_q     <= '0;
    end else if (step_i) begin
      last_q   <= last_d;
      stable_q <= stable_d;
      armed_q  <= armed_d;
      ct_q     <= ct_d;
    end
  end

endmodule

FILE: rtl/core/bdsd_merge.sv
// Merge stage: priority pick of lane presses, sequence detector and
// pending calibration flag. Depends on bdsd_pkg.
module bdsd_merge #(
  parameter int NUM_BUTTONS     = 5,
  parameter int SEQUENCE_LENGTH = 4,
  parameter int TIME_WIDTH      = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,
  input  bdsd_pkg::mode_e          mode_i,
  input  logic [TIME_WIDTH-1:0]    now_i,
  input  logic [NUM_BUTTONS-1:0]   press_i,
  input  logic [2*NUM_BUTTONS-1:0] table_i,
  input  logic [15:0]              timeout_i,
  output logic [1:0]               event_o,
  output logic                     taken_o
);
  import bdsd_pkg::*;

  localparam int IdxW  = $clog2(NUM_BUTTONS);
  localparam int StepW = $clog2(SEQUENCE_LENGTH);
  localparam int CmpW  = (IdxW > StepW) ? IdxW : StepW;

  logic [StepW-1:0]      step_q, step_d;
  logic [TIME_WIDTH-1:0] start_q, start_d;
  logic                  pending_q, pending_d;

  logic [IdxW-1:0]       first_idx;
  logic [1:0]            code;
  logic                  any_press;
  logic                  multi_press;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  timed_out;
  logic [StepW-1:0]      s0;
  logic [StepW-1:0]      s1;
  logic                  restarted;
  logic                  expired_end;

  // Lowest pressed lane feeds the detector; lowest pressed lane with a
  // nonzero code gives the event.
  always_comb begin
    first_idx = '0;
    code      = 2'd0;
    for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
      if (press_i[i]) begin
        first_idx = IdxW'(i);
        if (table_i[2*i +: 2] != 2'd0) begin
          code = table_i[2*i +: 2];
        end
      end
    end
  end

  assign any_press   = |press_i;
  assign multi_press = (press_i & (press_i - NUM_BUTTONS'(1))) != '0;
  assign elapsed     = now_i - start_q;
  assign timed_out   = elapsed >= TIME_WIDTH'(timeout_i);

  always_comb begin
    s0          = (step_q != '0 && timed_out) ? '0 : step_q;
    s1          = step_q;
    restarted   = 1'b0;
    expired_end = 1'b0;
    pending_d   = pending_q;
    start_d     = start_q;
    event_o     = 2'd0;
    taken_o     = 1'b0;
    step_d      = step_q;
    unique case (mode_i)
      MODE_POLL: begin
        event_o = code;
        if (any_press) begin
          if (first_idx == '0) begin
            s1        = StepW'(1);
            start_d   = now_i;
            restarted = 1'b1;
          end else if (int'(first_idx) < SEQUENCE_LENGTH &&
                       CmpW'(first_idx) == CmpW'(s0)) begin
            if (int'(s0) == SEQUENCE_LENGTH - 1) begin
              s1        = '0;
              pending_d = 1'b1;
            end else begin
              s1 = s0 + StepW'(1);
            end
          end else begin
            s1 = '0;
          end
          if (multi_press) begin
            s1 = '0;
          end
        end
        // A run restarted in this request has zero elapsed time.
        expired_end = (s1 != '0) &&
                      (restarted ? (timeout_i == 16'd0) : timed_out);
        step_d = expired_end ? '0 : s1;
      end
      MODE_INIT: begin
        pending_d = 1'b0;
        step_d    = '0;
        start_d   = now_i;
      end
      MODE_TAKE: begin
        taken_o   = pending_q;
        pending_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= '0;
      start_q   <= '0;
      pending_q <= 1'b0;
    end else if (step_i) begin
      step_q    <= step_d;
      start_q   <= start_d;
      pending_q <= pending_d;
    end
  end

endmodule

FILE: rtl/core/bdsd_outbuf.sv
// Two-entry result buffer that decouples the input and output handshakes.
// Self-contained; depends on nothing else.
module bdsd_outbuf #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         ready_o,
  output logic         valid_o,
  input  logic         pop_ready_i,
  output logic [W-1:0] data_o
);

  logic [W-1:0] mem_q [2];
  logic         wr_q, rd_q;
  logic [1:0]   cnt_q, cnt_d;
  logic         pop;

  assign ready_o = cnt_q != 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rd_q];
  assign pop     = valid_o && pop_ready_i;

  always_comb begin
    case ({push_i, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

FILE: bench/button_debounce_sequence_detect_core_tb.sv
// Testbench for button_debounce_sequence_detect_core: drives poll, init, take and unused-mode requests
// and checks every result against a cycle-free model of the debouncer and sequence detector.
// Depends on bdsd_pkg and the core RTL only.
`timescale 1ns / 1ps

module button_debounce_sequence_detect_core_tb;
  import bdsd_pkg::*;

  localparam int NUM_BTN        = 5;
  localparam int SEQ_LEN        = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 60;
  localparam int REPORT_LIMIT   = 10;
  localparam logic [1:0] REG_UNUSED  = 2'd3;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]         code;
    logic               taken;
    logic [NUM_BTN-1:0] stable;
  } btn_result_t;

  // Tracks debounce lanes, arming and the sequence detector, and holds the
  // results still owed by the block in request order.
  class button_event_tracker;
    logic [15:0]        debounce_ms;
    logic [15:0]        timeout_ms;
    logic [9:0]         msg_table;
    logic [NUM_BTN-1:0] raw_q;
    logic [NUM_BTN-1:0] stable_q;
    logic [NUM_BTN-1:0] armed_q;
    logic [31:0]        change_ms[NUM_BTN];
    logic [2:0]         seq_step;
    logic [31:0]        seq_start_ms;
    logic               cal_pending;
    btn_result_t        expected_events[$];
    int unsigned        fail_count;

    function new();
      debounce_ms  = DEBOUNCE_RESET;
      timeout_ms   = TIMEOUT_RESET;
      msg_table    = TABLE_RESET[9:0];
      raw_q        = '0;
      stable_q     = '0;
      armed_q      = '0;
      foreach (change_ms[i]) change_ms[i] = '0;
      seq_step     = '0;
      seq_start_ms = '0;
      cal_pending  = 1'b0;
      fail_count   = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      if (idx == REG_DEBOUNCE) debounce_ms = data;
      else if (idx == REG_TIMEOUT) timeout_ms = data;
      else if (idx == REG_TABLE) msg_table = data[9:0];
    endfunction

    function bit run_expired(logic [31:0] now);
      logic [31:0] elapsed;
      elapsed = now - seq_start_ms;
      return (seq_step != 0) && (elapsed >= {16'b0, timeout_ms});
    endfunction

    function void feed_sequence(int unsigned idx, logic [31:0] now);
      if (run_expired(now)) seq_step = 0;
      if (idx == 0) begin
        seq_step     = 1;
        seq_start_ms = now;
      end else if (idx < SEQ_LEN && seq_step == idx) begin
        seq_step = seq_step + 1;
        if (seq_step == SEQ_LEN) begin
          cal_pending = 1'b1;
          seq_step    = 0;
        end
      end else begin
        seq_step = 0;
      end
    endfunction

    function void note_request(logic [1:0] md, logic [31:0] now, logic [NUM_BTN-1:0] pins);
      logic [NUM_BTN-1:0] pressed;
      logic [31:0]        elapsed;
      btn_result_t        res;
      bit                 seen;
      pressed = ~pins;
      res     = '0;
      seen    = 1'b0;
      if (md == MODE_INIT) begin
        raw_q    = pressed;
        stable_q = pressed;
        armed_q  = ~pressed;
        foreach (change_ms[i]) change_ms[i] = now;
        cal_pending  = 1'b0;
        seq_step     = 0;
        seq_start_ms = now;
      end else if (md == MODE_TAKE) begin
        res.taken   = cal_pending;
        cal_pending = 1'b0;
      end else if (md == MODE_POLL) begin
        for (int i = 0; i < NUM_BTN; i++) begin
          if (pressed[i] != raw_q[i]) begin
            raw_q[i]     = pressed[i];
            change_ms[i] = now;
          end
          elapsed = now - change_ms[i];
          if (pressed[i] != stable_q[i] && elapsed >= {16'b0, debounce_ms}) begin
            stable_q[i] = pressed[i];
            if (!pressed[i]) begin
              armed_q[i] = 1'b1;
            end else if (armed_q[i]) begin
              // Only the lowest new press advances the detector; any further
              // press in the same poll breaks the run.
              if (!seen) begin
                feed_sequence(i, now);
                seen = 1'b1;
              end else begin
                seq_step = 0;
              end
              if (msg_table[2*i +: 2] != 0 && res.code == 0) res.code = msg_table[2*i +: 2];
            end
          end
        end
        if (run_expired(now)) seq_step = 0;
      end
      res.stable = stable_q;
      expected_events.push_back(res);
    endfunction

    function void check_result(btn_result_t got);
      btn_result_t exp;
      if (expected_events.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("%0t: result with no request pending: code=%0d taken=%0d stable=%b",
                   $realtime, got.code, got.taken, got.stable);
      end else begin
        exp = expected_events.pop_front();
        if (got !== exp) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("%0t: mismatch: code exp %0d got %0d, taken exp %0d got %0d, stable exp %b got %b",
                     $realtime, exp.code, got.code, exp.taken, got.taken, exp.stable, got.stable);
        end
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [1:0]         cfg_idx;
  logic [15:0]        cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         mode;
  logic [31:0]        now_ms;
  logic [NUM_BTN-1:0] pin_levels;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         event_code;
  logic               calibration_taken;
  logic [NUM_BTN-1:0] btn_stable;

  button_event_tracker tracker = new();

  logic [31:0] t_ms;
  int unsigned items_sent;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned hold_left;
  int unsigned idle_cycles;
  bit          hold_off_req;

  button_debounce_sequence_detect_core i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .cfg_idx_i           (cfg_idx),
    .cfg_wdata_i         (cfg_wdata),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .mode_i              (mode),
    .now_ms_i            (now_ms),
    .pin_levels_i        (pin_levels),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .event_code_o        (event_code),
    .calibration_taken_o (calibration_taken),
    .btn_stable_o        (btn_stable)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: random back-pressure, or a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (hold_off_req) begin
      hold_off_req = 1'b0;
      hold_left    = HOLD_CYCLES - 1;
      out_ready   <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin : result_monitor
    btn_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.code   = event_code;
      got.taken  = calibration_taken;
      got.stable = btn_stable;
      tracker.check_result(got);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Offers one request at the current time stamp; called and left at a falling edge.
  task automatic send_req(logic [1:0] md, logic [NUM_BTN-1:0] pins);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    mode       <= md;
    now_ms     <= t_ms;
    pin_levels <= pins;
    in_valid   <= 1'b1;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    tracker.note_request(md, t_ms, pins);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Press and release the buttons in mask, holding each level exactly long
  // enough to settle; with bounce, the edges chatter and the hold may stop
  // one millisecond short first.
  task automatic tap(logic [NUM_BTN-1:0] mask, bit bouncy);
    int unsigned deb;
    deb = tracker.debounce_ms;
    if (bouncy) repeat ($urandom_range(0, 2)) begin
      send_req(MODE_POLL, ~(mask & NUM_BTN'($urandom())));
      t_ms += $urandom_range(0, 3);
    end
    send_req(MODE_POLL, ~mask);
    if (bouncy && deb > 0 && $urandom_range(0, 2) == 0) begin
      t_ms += deb - 1;
      send_req(MODE_POLL, ~mask);
      t_ms += 1;
    end else begin
      t_ms += deb;
    end
    send_req(MODE_POLL, ~mask);
    if (bouncy) begin
      t_ms += $urandom_range(0, 3);
      repeat ($urandom_range(0, 2)) begin
        send_req(MODE_POLL, ~(mask & NUM_BTN'($urandom())));
        t_ms += $urandom_range(0, 3);
      end
    end
    t_ms += 1;
    send_req(MODE_POLL, '1);
    t_ms += deb;
    send_req(MODE_POLL, '1);
  endtask

  // Mostly the calibration order 0..3, with stray buttons, double presses and
  // gaps around the timeout mixed in.
  task automatic run_sequence();
    int unsigned        tmo;
    int unsigned        btn;
    logic [NUM_BTN-1:0] mask;
    tmo = tracker.timeout_ms;
    for (int k = 0; k < SEQ_LEN; k++) begin
      btn  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, NUM_BTN - 1) : k;
      mask = NUM_BTN'(1) << btn;
      if ($urandom_range(0, 11) == 0) mask |= NUM_BTN'(1) << $urandom_range(0, NUM_BTN - 1);
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0: t_ms += tmo;
          1: t_ms += tmo + 1;
          2: t_ms += (tmo > 0) ? tmo - 1 : 0;
          default: t_ms += $urandom_range(0, 2 * tmo + 2);
        endcase
      end else begin
        t_ms += $urandom_range(0, 20);
      end
      tap(mask, 1'b1);
    end
    if ($urandom_range(0, 9) < 7) send_req(MODE_TAKE, NUM_BTN'($urandom()));
  endtask

  task automatic run_phase(int unsigned n);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = items_sent + n;
    t_ms = $urandom_range(0, 1) ? $urandom() : 32'hFFFF_FFFF - $urandom_range(0, 3000);
    send_req(MODE_INIT, '1);
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        run_sequence();
      end else if (pick < 70) begin
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(0, 2))
            0: t_ms = $urandom();
            1: t_ms += $urandom_range(0, 40);
            default: ;
          endcase
          send_req(2'($urandom_range(0, 3)), NUM_BTN'($urandom()));
        end
      end else if (pick < 78) begin
        send_req(MODE_INIT, NUM_BTN'($urandom()));
      end else if (pick < 86) begin
        send_req(MODE_TAKE, NUM_BTN'($urandom()));
      end else begin
        tap(NUM_BTN'($urandom_range(1, 31)), 1'b1);
      end
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.expected_events.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // Registers are only written while nothing is in flight.
  task automatic configure(logic [15:0] deb, logic [15:0] tmo, logic [15:0] tbl,
                           bit poke_unused);
    logic [1:0]  idx_list[4];
    logic [15:0] data_list[4];
    int          n;
    idx_list  = '{REG_DEBOUNCE, REG_TIMEOUT, REG_TABLE, REG_UNUSED};
    data_list = '{deb, tmo, tbl, 16'($urandom())};
    n = poke_unused ? 4 : 3;
    for (int i = 0; i < n; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= idx_list[i];
      cfg_wdata <= data_list[i];
      @(posedge clk_i);
      tracker.write_reg(idx_list[i], data_list[i]);
      @(negedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_idx    = '0;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    mode       = MODE_POLL;
    now_ms     = '0;
    pin_levels = '1;
    out_ready  = 1'b0;
    items_sent = 0;
    tx_idle_pct = 19;
    rx_idle_pct = 58;
    repeat (2) @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // Directed: unused mode, init, empty take, the full calibration order
    // across the time wrap, a pending take, a double press and an init with
    // every button held down.
    t_ms = 32'hFFFF_FFE0;
    send_req(MODE_UNUSED, '0);
    send_req(MODE_INIT, '1);
    send_req(MODE_TAKE, '1);
    for (int k = 0; k < SEQ_LEN; k++) tap(NUM_BTN'(1) << k, 1'b0);
    send_req(MODE_TAKE, '0);
    tap(5'b00110, 1'b0);
    send_req(MODE_INIT, '0);
    wait_drained();

    run_phase(200);
    wait_drained();

    configure(16'd0, 16'hFFFF, 16'hFFFF, 1'b0);
    tx_idle_pct = 58;
    rx_idle_pct = 19;
    run_phase(200);
    wait_drained();

    configure(16'($urandom_range(1, 100)), 16'($urandom_range(200, 3000)),
              16'($urandom()), 1'b1);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_off_req = 1'b1;
    run_phase(150);
    wait_drained();

    configure(16'hFFFF, 16'd0, 16'd0, 1'b0);
    run_phase(100);
    wait_drained();

    repeat (8) @(negedge clk_i);
    if (tracker.expected_events.size() != 0) tracker.fail_count++;
    if (tracker.fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/bdsd_pkg.sv
rtl/core/bdsd_lane.sv
rtl/core/bdsd_merge.sv
rtl/core/bdsd_outbuf.sv
rtl/core/button_debounce_sequence_detect_core.sv
bench/button_debounce_sequence_detect_core_tb.sv
